@@ hw/rtl/suffix_array_pattern_counter_core_macros.svh @@
// assertion helpers for the pattern counter
`ifndef SUFFIX_ARRAY_PATTERN_COUNTER_CORE_MACROS_SVH
`define SUFFIX_ARRAY_PATTERN_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define SAPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SAPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/sapc_pkg.sv @@
`default_nettype none
package sapc_pkg;

  localparam int unsigned CountW = 11;

  typedef enum logic {
    KIND_TEXT    = 1'b0,
    KIND_PATTERN = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              text_trunc;
    logic              pat_trunc;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/sapc_fifo.sv @@
`default_nettype none
module sapc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sapc_front.sv @@
`default_nettype none
module sapc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          last_i,
  output logic               full_o,
  output sapc_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);

  sapc_pkg::cmd_t cmd_in;
  logic           q_empty;

  // classify the request into a command for the back end
  always_comb begin
    cmd_in.kind = req_type_i ? sapc_pkg::KIND_PATTERN : sapc_pkg::KIND_TEXT;
    cmd_in.data = data_byte_i;
    cmd_in.last = last_i;
  end

  sapc_fifo #(
    .WIDTH($bits(sapc_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_ready_i),
    .data_o (cmd_o),
    .empty_o(q_empty)
  );

  assign cmd_valid_o = !q_empty;

endmodule
`default_nettype wire

@@ hw/rtl/sapc_engine.sv @@
`default_nettype none
module sapc_engine #(
  parameter int unsigned MAX_TEXT    = 1024,
  parameter int unsigned MAX_PATTERN = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sapc_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  output sapc_pkg::res_t     res_o,
  output logic               res_valid_o,
  input  wire logic          res_full_i
);

  localparam int unsigned TW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned LW  = $clog2(MAX_TEXT + 1);
  localparam int unsigned SW  = LW + 2;
  localparam int unsigned PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PLW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned XW  = ((LW > PLW) ? LW : PLW) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_BLK, S_RDSA, S_MRG, S_CPYP, S_CPYQ, S_CMPRD, S_CMPCHK,
    S_BS, S_PSA, S_PWAIT, S_PRD, S_PCHK, S_RET, S_LCHK
  } state_e;

  typedef enum logic [1:0] {MODE_BS, MODE_LEFT, MODE_RIGHT} mode_e;
  typedef enum logic [1:0] {CMP_LT, CMP_EQ, CMP_GT} cmp_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  cmp_e   cres_q, cres_d;
  logic   emit_q, emit_d;

  logic [LW-1:0]  tlen_q, tlen_d;
  logic           topen_q, topen_d, tovf_q, tovf_d;
  logic [PLW-1:0] plen_q, plen_d;
  logic           povf_q, povf_d;
  logic           bank_q, bank_d;
  logic [SW-1:0]  w_q, w_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [SW-1:0]  p_q, p_d, q_q, q_d, k_q, k_d;
  logic [LW-1:0]  xa_q, xa_d, xb_q, xb_d;
  logic [TW-1:0]  vp_q, vp_d, vq_q, vq_d;
  logic [LW-1:0]  l_q, l_d, rp_q, rp_d, md_q, md_d, idx_q, idx_d;
  logic [LW-1:0]  lft_q, lft_d, rgt_q, rgt_d, cnt_q, cnt_d, pos_q, pos_d;
  logic [PLW-1:0] i_q, i_d;

  logic [7:0]    text_mem [MAX_TEXT];
  logic [7:0]    pat_mem [MAX_PATTERN];
  logic [TW-1:0] sa_mem [2**(TW+1)];

  logic          tx_we, pt_we, sa_we;
  logic [TW-1:0] tx_wa, tx_ra, tx_rb, sa_wd;
  logic [PW-1:0] pt_wa, pt_ra;
  logic [TW:0]   sa_wa, sa_ra, sa_rb;
  logic [7:0]    tra_q, trb_q, pr_q;
  logic [TW-1:0] saa_q, sab_q;

  logic [SW-1:0] n_s, w2, sum_mid, sum_hi, md_s;
  logic [LW-1:0] eff_len;
  logic          fits_t, fits_p;
  logic [XW-1:0] t_s;
  logic          take;
  logic [LW+sapc_pkg::CountW-1:0] cnt_ext;

  assign n_s     = SW'(tlen_q);
  assign w2      = w_q << 1;
  assign sum_mid = lo_q + w_q;
  assign sum_hi  = lo_q + w2;
  assign md_s    = SW'(l_q) + ((SW'(rp_q) - SW'(1) - SW'(l_q)) >> 1);
  assign eff_len = topen_q ? tlen_q : '0;
  assign fits_t  = (SW'(eff_len) < SW'(MAX_TEXT));
  assign fits_p  = (XW'(plen_q) < XW'(MAX_PATTERN));
  assign t_s     = XW'(pos_q) + XW'(i_q);
  assign cnt_ext = (LW + sapc_pkg::CountW)'(cnt_q);

  assign cmd_ready_o       = (state_q == S_IDLE) && !emit_q;
  assign res_valid_o       = emit_q;
  assign res_o.count       = cnt_ext[sapc_pkg::CountW-1:0];
  assign res_o.text_trunc  = tovf_q;
  assign res_o.pat_trunc   = povf_q;

  always_comb begin
    state_d = state_q; mode_d = mode_q; cres_d = cres_q; emit_d = emit_q;
    tlen_d = tlen_q; topen_d = topen_q; tovf_d = tovf_q;
    plen_d = plen_q; povf_d = povf_q; bank_d = bank_q;
    w_d = w_q; lo_d = lo_q; mid_d = mid_q; hi_d = hi_q;
    p_d = p_q; q_d = q_q; k_d = k_q; xa_d = xa_q; xb_d = xb_q;
    vp_d = vp_q; vq_d = vq_q; l_d = l_q; rp_d = rp_q; md_d = md_q; idx_d = idx_q;
    lft_d = lft_q; rgt_d = rgt_q; cnt_d = cnt_q; pos_d = pos_q; i_d = i_q;
    tx_we = 1'b0; tx_wa = eff_len[TW-1:0];
    pt_we = 1'b0; pt_wa = plen_q[PW-1:0];
    sa_we = 1'b0; sa_wa = {~bank_q, k_q[TW-1:0]}; sa_wd = vp_q;
    tx_ra = xa_q[TW-1:0]; tx_rb = xb_q[TW-1:0];
    pt_ra = i_q[PW-1:0];
    sa_ra = {bank_q, p_q[TW-1:0]}; sa_rb = {bank_q, q_q[TW-1:0]};
    take = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (emit_q) begin
          if (!res_full_i) begin
            emit_d = 1'b0;
            plen_d = '0;
            povf_d = 1'b0;
          end
        end else if (cmd_valid_i) begin
          if (cmd_i.kind == sapc_pkg::KIND_TEXT) begin
            tx_we   = fits_t;
            tlen_d  = eff_len + LW'(fits_t);
            tovf_d  = (topen_q && tovf_q) || !fits_t;
            topen_d = !cmd_i.last;
            if (cmd_i.last) begin
              k_d     = '0;
              state_d = S_INIT;
            end
          end else begin
            pt_we  = fits_p;
            plen_d = plen_q + PLW'(fits_p);
            povf_d = povf_q || !fits_p;
            if (cmd_i.last) begin
              if (topen_q || tlen_q == '0) begin
                cnt_d  = '0;
                emit_d = 1'b1;
              end else begin
                l_d     = '0;
                rp_d    = tlen_q;
                state_d = S_BS;
              end
            end
          end
        end
      end
      S_INIT: begin
        sa_we = 1'b1;
        sa_wa = {bank_q, k_q[TW-1:0]};
        sa_wd = k_q[TW-1:0];
        k_d   = k_q + SW'(1);
        if (k_q + SW'(1) >= n_s) begin
          w_d  = SW'(1);
          lo_d = '0;
          state_d = (n_s <= SW'(1)) ? S_IDLE : S_BLK;
        end
      end
      S_BLK: begin
        if (lo_q >= n_s) begin
          bank_d = ~bank_q;
          w_d    = w2;
          lo_d   = '0;
          if (w2 >= n_s) begin
            state_d = S_IDLE;
          end
        end else begin
          mid_d   = (sum_mid < n_s) ? sum_mid : n_s;
          hi_d    = (sum_hi < n_s) ? sum_hi : n_s;
          p_d     = lo_q;
          q_d     = (sum_mid < n_s) ? sum_mid : n_s;
          k_d     = lo_q;
          state_d = S_RDSA;
        end
      end
      S_RDSA: begin
        if (p_q < mid_q && q_q < hi_q) begin
          state_d = S_MRG;
        end else if (p_q < mid_q) begin
          state_d = S_CPYP;
        end else if (q_q < hi_q) begin
          state_d = S_CPYQ;
        end else begin
          lo_d    = hi_q;
          state_d = S_BLK;
        end
      end
      S_MRG: begin
        vp_d    = saa_q;
        vq_d    = sab_q;
        xa_d    = LW'(sab_q);
        xb_d    = LW'(saa_q);
        state_d = S_CMPRD;
      end
      S_CPYP: begin
        sa_we   = 1'b1;
        sa_wd   = saa_q;
        p_d     = p_q + SW'(1);
        k_d     = k_q + SW'(1);
        state_d = S_RDSA;
      end
      S_CPYQ: begin
        sa_we   = 1'b1;
        sa_wd   = sab_q;
        q_d     = q_q + SW'(1);
        k_d     = k_q + SW'(1);
        state_d = S_RDSA;
      end
      S_CMPRD: begin
        if (xa_q < tlen_q && xb_q < tlen_q) begin
          state_d = S_CMPCHK;
        end else begin
          take   = (xa_q >= tlen_q) && (xb_q < tlen_q);
          sa_we  = 1'b1;
          sa_wd  = take ? vq_q : vp_q;
          p_d    = take ? p_q : p_q + SW'(1);
          q_d    = take ? q_q + SW'(1) : q_q;
          k_d    = k_q + SW'(1);
          state_d = S_RDSA;
        end
      end
      S_CMPCHK: begin
        if (tra_q != trb_q) begin
          take   = (tra_q < trb_q);
          sa_we  = 1'b1;
          sa_wd  = take ? vq_q : vp_q;
          p_d    = take ? p_q : p_q + SW'(1);
          q_d    = take ? q_q + SW'(1) : q_q;
          k_d    = k_q + SW'(1);
          state_d = S_RDSA;
        end else begin
          xa_d    = xa_q + LW'(1);
          xb_d    = xb_q + LW'(1);
          state_d = S_CMPRD;
        end
      end
      S_BS: begin
        if (l_q < rp_q) begin
          md_d    = md_s[LW-1:0];
          idx_d   = md_s[LW-1:0];
          mode_d  = MODE_BS;
          state_d = S_PSA;
        end else begin
          cnt_d   = '0;
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PSA: begin
        sa_ra   = {bank_q, idx_q[TW-1:0]};
        state_d = S_PWAIT;
      end
      S_PWAIT: begin
        pos_d   = LW'(saa_q);
        i_d     = '0;
        state_d = S_PRD;
      end
      S_PRD: begin
        tx_ra = t_s[TW-1:0];
        if (i_q == plen_q) begin
          cres_d  = CMP_EQ;
          state_d = S_RET;
        end else if (t_s >= XW'(tlen_q)) begin
          cres_d  = CMP_GT;
          state_d = S_RET;
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (pr_q != tra_q) begin
          cres_d  = (pr_q < tra_q) ? CMP_LT : CMP_GT;
          state_d = S_RET;
        end else begin
          i_d     = i_q + PLW'(1);
          state_d = S_PRD;
        end
      end
      S_RET: begin
        case (mode_q)
          MODE_BS: begin
            if (cres_q == CMP_EQ) begin
              cnt_d   = LW'(1);
              lft_d   = md_q;
              rgt_d   = md_q + LW'(1);
              state_d = S_LCHK;
            end else if (cres_q == CMP_LT) begin
              rp_d    = md_q;
              state_d = S_BS;
            end else begin
              l_d     = md_q + LW'(1);
              state_d = S_BS;
            end
          end
          MODE_LEFT: begin
            if (cres_q == CMP_EQ) begin
              cnt_d   = cnt_q + LW'(1);
              lft_d   = lft_q - LW'(1);
              state_d = S_LCHK;
            end else begin
              mode_d  = MODE_RIGHT;
              state_d = S_LCHK;
              lft_d   = '0;
            end
          end
          default: begin
            if (cres_q == CMP_EQ) begin
              cnt_d = cnt_q + LW'(1);
              rgt_d = rgt_q + LW'(1);
            end else begin
              rgt_d = tlen_q;
            end
            mode_d  = MODE_RIGHT;
            lft_d   = '0;
            state_d = S_LCHK;
          end
        endcase
      end
      S_LCHK: begin
        if (lft_q != '0) begin
          idx_d   = lft_q - LW'(1);
          mode_d  = MODE_LEFT;
          state_d = S_PSA;
        end else if (rgt_q < tlen_q) begin
          idx_d   = rgt_q;
          mode_d  = MODE_RIGHT;
          state_d = S_PSA;
        end else begin
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_BS;
      cres_q  <= CMP_EQ;
      emit_q  <= 1'b0;
      tlen_q  <= '0;
      topen_q <= 1'b0;
      tovf_q  <= 1'b0;
      plen_q  <= '0;
      povf_q  <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cres_q  <= cres_d;
      emit_q  <= emit_d;
      tlen_q  <= tlen_d;
      topen_q <= topen_d;
      tovf_q  <= tovf_d;
      plen_q  <= plen_d;
      povf_q  <= povf_d;
      bank_q  <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d; lo_q <= lo_d; mid_q <= mid_d; hi_q <= hi_d;
    p_q <= p_d; q_q <= q_d; k_q <= k_d; xa_q <= xa_d; xb_q <= xb_d;
    vp_q <= vp_d; vq_q <= vq_d; l_q <= l_d; rp_q <= rp_d; md_q <= md_d;
    idx_q <= idx_d; lft_q <= lft_d; rgt_q <= rgt_d; cnt_q <= cnt_d;
    pos_q <= pos_d; i_q <= i_d;
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      text_mem[tx_wa] <= cmd_i.data;
    end
    tra_q <= text_mem[tx_ra];
    trb_q <= text_mem[tx_rb];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pat_mem[pt_wa] <= cmd_i.data;
    end
    pr_q <= pat_mem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sa_we) begin
      sa_mem[sa_wa] <= sa_wd;
    end
    saa_q <= sa_mem[sa_ra];
    sab_q <= sa_mem[sa_rb];
  end

endmodule
`default_nettype wire

@@ hw/rtl/suffix_array_pattern_counter_core.sv @@
// text and pattern bytes are taken one per cycle, while the engine is idle, through a
// two-entry command queue; the last text byte starts a merge sort of n suffixes that seeds
// the suffix array, then merges blocks in ceil(log2 n) passes, copying or comparing suffixes
// the last pattern byte starts a binary search and a left/right scan over a loaded text, each
// probe comparing the pattern byte by byte with a suffix; counts wait in a 2-entry queue
// reset is asynchronous and active low and leaves no text loaded and both queues empty
`default_nettype none
module suffix_array_pattern_counter_core #(
  parameter int unsigned MAX_TEXT    = 1024,
  parameter int unsigned MAX_PATTERN = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [10:0]      match_count_o,
  output logic             text_truncated_o,
  output logic             pattern_truncated_o
);

  sapc_pkg::cmd_t cmd;
  sapc_pkg::res_t res, res_out;
  logic           cmd_valid, cmd_ready, res_valid, res_full;

  sapc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_type_i (req_type_i),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .full_o     (full),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready)
  );

  sapc_engine #(
    .MAX_TEXT   (MAX_TEXT),
    .MAX_PATTERN(MAX_PATTERN)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .res_o      (res),
    .res_valid_o(res_valid),
    .res_full_i (res_full)
  );

  sapc_fifo #(
    .WIDTH($bits(sapc_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign match_count_o       = res_out.count;
  assign text_truncated_o    = res_out.text_trunc;
  assign pattern_truncated_o = res_out.pat_trunc;

endmodule
`default_nettype wire

@@ hw/rtl/sapc_checker.sv @@
`default_nettype none
`include "suffix_array_pattern_counter_core_macros.svh"
module sapc_checker #(
  parameter int unsigned MAX_TEXT = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [10:0] match_count_o
);

  `SAPC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(match_count_o))
  `SAPC_ASSERT_NOW(a_range, !empty, 32'(match_count_o) <= MAX_TEXT)
  `SAPC_ASSERT_NOW(a_reset_empty, $rose(rst_ni), empty)

endmodule

bind suffix_array_pattern_counter_core sapc_checker #(.MAX_TEXT(MAX_TEXT)) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .match_count_o(match_count_o)
);
`default_nettype wire
